FILE: rtl/rams_pkg.sv
package rams_pkg;

    localparam int ELEMENT_WIDTH_DEF  = 24;
    localparam int ACC_WIDTH_DEF      = 48;
    localparam int REPEAT_WIDTH       = 16;
    localparam int RESULT_WIDTH       = 64;
    localparam int APB_ADDR_WIDTH     = 3;
    localparam int APB_DATA_WIDTH     = 32;
    localparam int REG_INDEX_WIDTH    = APB_ADDR_WIDTH - 2;

    // register map, by word index
    localparam logic [REG_INDEX_WIDTH-1:0] REG_REPEAT_COUNT = '0;

    localparam logic [REPEAT_WIDTH-1:0] REPEAT_COUNT_RESET = REPEAT_WIDTH'(1);

    typedef logic signed [RESULT_WIDTH-1:0] result_t;
    typedef logic signed [RESULT_WIDTH:0]   wide_sum_t;

    localparam result_t RESULT_MAX = {1'b0, {(RESULT_WIDTH-1){1'b1}}};
    localparam result_t RESULT_MIN = {1'b1, {(RESULT_WIDTH-1){1'b0}}};

    // clamp a one-bit-wider sum into the result range
    function automatic result_t sat_result(input wide_sum_t s);
        result_t r;
        if (s[RESULT_WIDTH] != s[RESULT_WIDTH-1]) begin
            r = s[RESULT_WIDTH] ? RESULT_MIN : RESULT_MAX;
        end else begin
            r = s[RESULT_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/repeated_array_max_subarray_sum_core.sv
// Streams signed array elements, one beat per cycle, and on the beat marked
// last returns the largest non-empty subarray sum over the array repeated
// repeat_count times (a count of 0 or 1 means one copy), saturated to 64 bits.
// The running accumulators saturate at ACC_WIDTH bits and clear after every
// last beat, so the next array may follow in the very next cycle. Elements
// are taken at one per cycle; the result of an array is registered through
// three stages of final combination, whose 64x16 multiply is split into two
// partial products, the last stage loading the output register. Input ready
// drops only when the result stages are full and the output is stalled.
// repeat_count sits at byte address 0 of the APB port and must only be
// written while the block holds no array in progress.
module repeated_array_max_subarray_sum_core #(
    parameter int ELEMENT_WIDTH = rams_pkg::ELEMENT_WIDTH_DEF,
    parameter int ACC_WIDTH     = rams_pkg::ACC_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [ELEMENT_WIDTH-1:0]       s_element,
    input  logic                                  s_last,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [rams_pkg::RESULT_WIDTH-1:0] m_max_sum,

    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [rams_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  logic [rams_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic [rams_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                  pready
);
    import rams_pkg::*;

    typedef logic signed [ACC_WIDTH-1:0] acc_t;
    typedef logic signed [ACC_WIDTH:0]   acc_wide_t;

    localparam acc_t ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam acc_t ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    localparam int   LO_WIDTH = 32;
    localparam int   HI_WIDTH = RESULT_WIDTH - 1 - LO_WIDTH;
    localparam int   PROD_WIDTH = RESULT_WIDTH + REPEAT_WIDTH;

    typedef logic [PROD_WIDTH-1:0] prod_t;

    function automatic acc_t acc_add(input acc_t a, input acc_t b);
        acc_wide_t s;
        acc_t      r;
        s = (ACC_WIDTH+1)'(a) + (ACC_WIDTH+1)'(b);
        if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
            r = s[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
        end else begin
            r = s[ACC_WIDTH-1:0];
        end
        return r;
    endfunction

    // ---------------- configuration ----------------
    logic [REPEAT_WIDTH-1:0]    repeat_count_reg;
    logic [REG_INDEX_WIDTH-1:0] reg_index;
    logic                       cfg_write;

    assign reg_index = paddr[APB_ADDR_WIDTH-1:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            repeat_count_reg <= REPEAT_COUNT_RESET;
        end else if (cfg_write && reg_index == REG_REPEAT_COUNT) begin
            repeat_count_reg <= pwdata[REPEAT_WIDTH-1:0];
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_REPEAT_COUNT: prdata = APB_DATA_WIDTH'(repeat_count_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------- pipeline flow control ----------------
    logic p1_valid_reg, p2_valid_reg, p3_valid_reg, out_valid_reg;
    logic out_free, p3_free, p2_free, p1_free;
    logic in_beat;

    assign out_free = !out_valid_reg || m_ready;
    assign p3_free  = !p3_valid_reg || out_free;
    assign p2_free  = !p2_valid_reg || p3_free;
    assign p1_free  = !p1_valid_reg || p2_free;
    assign s_ready  = p1_free;
    assign in_beat  = s_valid && s_ready;

    // ---------------- running accumulators ----------------
    acc_t run_sum_reg, best_run_reg, total_sum_reg, best_prefix_reg, lpp_reg;
    logic seen_any_reg;
    acc_t x_acc, run_add, total_add, lpp_upd, best_run_upd, best_prefix_upd, run_clip;

    assign x_acc     = ACC_WIDTH'(s_element);
    assign run_add   = acc_add(run_sum_reg, x_acc);
    assign total_add = acc_add(total_sum_reg, x_acc);
    // total before this element is a proper prefix
    assign lpp_upd   = (total_sum_reg < lpp_reg) ? total_sum_reg : lpp_reg;
    assign best_run_upd    = (!seen_any_reg || run_add > best_run_reg) ? run_add : best_run_reg;
    assign best_prefix_upd = (!seen_any_reg || total_add > best_prefix_reg)
                             ? total_add : best_prefix_reg;
    assign run_clip  = run_add[ACC_WIDTH-1] ? '0 : run_add;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_sum_reg     <= '0;
            total_sum_reg   <= '0;
            lpp_reg         <= '0;
            best_run_reg    <= '0;
            best_prefix_reg <= '0;
            seen_any_reg    <= 1'b0;
        end else if (in_beat) begin
            if (s_last) begin
                run_sum_reg   <= '0;
                total_sum_reg <= '0;
                lpp_reg       <= '0;
                seen_any_reg  <= 1'b0;
            end else begin
                run_sum_reg     <= run_clip;
                total_sum_reg   <= total_add;
                lpp_reg         <= lpp_upd;
                best_run_reg    <= best_run_upd;
                best_prefix_reg <= best_prefix_upd;
                seen_any_reg    <= 1'b1;
            end
        end
    end

    // ---------------- stage 1: suffix and partial products ----------------
    acc_t                    p1_best_run_reg, p1_total_reg, p1_best_prefix_reg, p1_lpp_reg;
    logic                    p1_wrap_en_reg;
    logic [REPEAT_WIDTH-1:0] p1_mult_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (p1_free) begin
            p1_valid_reg <= in_beat && s_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_free && in_beat && s_last) begin
            p1_best_run_reg    <= best_run_upd;
            p1_total_reg       <= total_add;
            p1_best_prefix_reg <= best_prefix_upd;
            p1_lpp_reg         <= lpp_upd;
            p1_wrap_en_reg     <= repeat_count_reg >= REPEAT_WIDTH'(2);
            p1_mult_reg        <= repeat_count_reg - REPEAT_WIDTH'(2);
        end
    end

    result_t                            suffix_sat;
    logic [RESULT_WIDTH-1:0]            total_pos;
    logic [LO_WIDTH+REPEAT_WIDTH-1:0]   pp_lo;
    logic [HI_WIDTH+REPEAT_WIDTH-1:0]   pp_hi;

    assign suffix_sat = sat_result(wide_sum_t'(p1_total_reg) - wide_sum_t'(p1_lpp_reg));
    // only a positive total adds middle copies
    assign total_pos  = (p1_total_reg > acc_t'(0)) ? RESULT_WIDTH'(p1_total_reg) : '0;
    assign pp_lo = (LO_WIDTH+REPEAT_WIDTH)'(total_pos[LO_WIDTH-1:0])
                 * (LO_WIDTH+REPEAT_WIDTH)'(p1_mult_reg);
    assign pp_hi = (HI_WIDTH+REPEAT_WIDTH)'(total_pos[RESULT_WIDTH-2:LO_WIDTH])
                 * (HI_WIDTH+REPEAT_WIDTH)'(p1_mult_reg);

    // ---------------- stage 2: prefix plus suffix, product assembly ----------------
    result_t                          p2_suffix_reg, p2_best_run_reg, p2_best_prefix_reg;
    logic [LO_WIDTH+REPEAT_WIDTH-1:0] p2_pp_lo_reg;
    logic [HI_WIDTH+REPEAT_WIDTH-1:0] p2_pp_hi_reg;
    logic                             p2_wrap_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (p2_free) begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p2_free) begin
            p2_suffix_reg      <= suffix_sat;
            p2_best_run_reg    <= RESULT_WIDTH'(p1_best_run_reg);
            p2_best_prefix_reg <= RESULT_WIDTH'(p1_best_prefix_reg);
            p2_pp_lo_reg       <= pp_lo;
            p2_pp_hi_reg       <= pp_hi;
            p2_wrap_en_reg     <= p1_wrap_en_reg;
        end
    end

    result_t ps_sat, middle;
    prod_t   prod;

    assign ps_sat = sat_result(wide_sum_t'(p2_best_prefix_reg) + wide_sum_t'(p2_suffix_reg));
    assign prod   = (PROD_WIDTH'(p2_pp_hi_reg) << LO_WIDTH) + PROD_WIDTH'(p2_pp_lo_reg);
    assign middle = (prod > PROD_WIDTH'(RESULT_MAX)) ? RESULT_MAX : prod[RESULT_WIDTH-1:0];

    // ---------------- stage 3: wrap-around sum and final pick ----------------
    result_t p3_ps_reg, p3_middle_reg, p3_best_run_reg;
    logic    p3_wrap_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_valid_reg <= 1'b0;
        end else if (p3_free) begin
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p3_free) begin
            p3_ps_reg       <= ps_sat;
            p3_middle_reg   <= middle;
            p3_best_run_reg <= p2_best_run_reg;
            p3_wrap_en_reg  <= p2_wrap_en_reg;
        end
    end

    result_t wrap_sum, answer;

    assign wrap_sum = sat_result(wide_sum_t'(p3_ps_reg) + wide_sum_t'(p3_middle_reg));
    assign answer   = (p3_wrap_en_reg && wrap_sum > p3_best_run_reg) ? wrap_sum : p3_best_run_reg;

    // ---------------- output register ----------------
    result_t out_sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_sum_reg <= answer;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_max_sum = out_sum_reg;

endmodule

FILE: rtl/rams_checker.sv
module rams_checker (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic                                   s_ready,
    input logic                                   m_valid,
    input logic                                   m_ready,
    input logic signed [rams_pkg::RESULT_WIDTH-1:0] m_max_sum,
    input logic                                   psel,
    input logic                                   penable,
    input logic                                   pwrite,
    input logic [rams_pkg::APB_ADDR_WIDTH-1:0]    paddr,
    input logic [rams_pkg::APB_DATA_WIDTH-1:0]    pwdata,
    input logic [rams_pkg::APB_DATA_WIDTH-1:0]    prdata
);
    import rams_pkg::*;

    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_max_sum))
        else $error("result beat changed while stalled");

    // input backpressure only comes from a stalled output
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled with output free");

    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // written repeat count reads back
    assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && psel && penable && pwrite
            && paddr[APB_ADDR_WIDTH-1:2] == REG_REPEAT_COUNT
        |=> paddr[APB_ADDR_WIDTH-1:2] != REG_REPEAT_COUNT
            || prdata[REPEAT_WIDTH-1:0] == $past(pwdata[REPEAT_WIDTH-1:0]))
        else $error("repeat count readback mismatch");

endmodule

bind repeated_array_max_subarray_sum_core rams_checker u_rams_checker (.*);
